// ----- rtl/masc_pkg.sv -----
package masc_pkg;

  localparam int HeaderBytes = 48;
  localparam int HeaderCrcOffset = 40;
  localparam int HeaderResOffset = 44;
  localparam int MaxTracks = 256;
  localparam int TrackIdxW = 8;
  localparam logic [31:0] CrcPoly = 32'hedb88320;

  localparam logic [7:0] BindingBytes = 8'd16;
  localparam logic [7:0] ChannelBytes = 8'd8;
  localparam logic [7:0] TrackBytes = 8'd16;
  localparam logic [7:0] KeyBytes = 8'd16;

  localparam logic [2:0] CfgMagic = 3'd0;
  localparam logic [2:0] CfgVersion = 3'd1;
  localparam logic [2:0] CfgStep = 3'd2;
  localparam logic [2:0] CfgLinear = 3'd3;
  localparam logic [2:0] CfgHermite = 3'd4;

  typedef enum logic [3:0] {
    ERR_NONE = 4'd0, ERR_HDR = 4'd1, ERR_VER = 4'd2, ERR_RES = 4'd3, ERR_CNT = 4'd4,
    ERR_PSIZE = 4'd5, ERR_TIME = 4'd6, ERR_BIND = 4'd7, ERR_CHAN = 4'd8,
    ERR_TRACK = 4'd9, ERR_KEY = 4'd10, ERR_COVER = 4'd11, ERR_OVF = 4'd12
  } err_t;

  typedef enum logic [2:0] {
    SEC_BIND = 3'd0, SEC_CHAN = 3'd1, SEC_TRACK = 3'd2, SEC_KEY = 3'd3, SEC_DONE = 3'd4
  } sec_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } word_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) r = (r >> 1) ^ (r[0] ? CrcPoly : 32'd0);
    return r;
  endfunction

  function automatic logic fin(input logic [31:0] b);
    return b[30:23] != 8'hff;
  endfunction

  function automatic logic [31:0] ord(input logic [31:0] b);
    if (b[30:0] == 31'd0) return 32'h8000_0000;
    if (b[31]) return ~b;
    return b | 32'h8000_0000;
  endfunction

endpackage

// ----- rtl/masc_fifo.sv -----
module masc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  masc_pkg::word_t  wr_word,
  output logic             full,
  input  logic             rd_en,
  output masc_pkg::word_t  rd_word,
  output logic             empty
);
  import masc_pkg::*;

  word_t      mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full = cnt_r == 3'd4;
  assign empty = cnt_r == 3'd0;
  assign rd_word = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_word;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end
endmodule

// ----- rtl/masc_engine.sv -----
module masc_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_en,
  input  masc_pkg::word_t  in_word,
  input  logic [31:0]      magic_word,
  input  logic [15:0]      format_version,
  input  logic [15:0]      step_code,
  input  logic [15:0]      linear_code,
  input  logic [15:0]      hermite_code,
  output logic             res_en,
  output logic [3:0]       res_code
);
  import masc_pkg::*;

  localparam logic [33:0] CountCap = 34'h2_0000_0000;

  logic [33:0] cnt_r;
  logic [31:0] crc_r;
  logic [31:0] hf_r [10];
  logic [31:0] hcrc_r;
  logic [6:0]  flags_r;
  logic        parse_r;
  logic [7:0]  rbuf_r [16];
  sec_t        sec_r;
  logic [31:0] ridx_r;
  logic [7:0]  rbyte_r;
  logic [31:0] prev_node_r;
  logic [32:0] chan_cur_r, key_cur_r;
  logic [32:0] tstore_r [MaxTracks];
  logic [8:0]  good_r;
  logic        terr_r, kerr_r;
  logic [8:0]  tpos_r;
  logic [31:0] kleft_r;
  logic        first_r, have_r;
  logic [31:0] prev_t_r, min_r, max_r;
  logic [3:0]  sticky_r;
  logic [32:0] ts_rd_r;

  logic [7:0]  b;
  logic [33:0] pos;
  logic [31:0] crc_n;
  logic [7:0]  rec [16];
  logic [7:0]  rsize;
  logic        rec_done;
  logic [31:0] w0, w4, w8, w12;
  logic [15:0] h0, h2;
  logic [31:0] sec_n;
  logic [6:0]  fl;
  logic [35:0] pay;
  logic        herm;

  always_comb begin
    b = in_word.data;
    pos = cnt_r;
    crc_n = crc_byte(crc_r, b);
    for (int i = 0; i < 16; i++) rec[i] = rbuf_r[i];
    if (rbyte_r < 8'd16) rec[rbyte_r[3:0]] = b;
    unique case (sec_r)
      SEC_BIND: rsize = BindingBytes;
      SEC_CHAN: rsize = ChannelBytes;
      SEC_TRACK: rsize = TrackBytes;
      default: rsize = KeyBytes;
    endcase
    rec_done = (rbyte_r + 8'd1) >= rsize;
    w0 = {rec[3], rec[2], rec[1], rec[0]};
    w4 = {rec[7], rec[6], rec[5], rec[4]};
    w8 = {rec[11], rec[10], rec[9], rec[8]};
    w12 = {rec[15], rec[14], rec[13], rec[12]};
    h0 = w0[15:0];
    h2 = w0[31:16];
    unique case (sec_r)
      SEC_BIND: sec_n = hf_r[3];
      SEC_CHAN: sec_n = hf_r[4];
      SEC_TRACK: sec_n = hf_r[5];
      default: sec_n = hf_r[6];
    endcase
    // header summary, evaluated when the last header byte arrives
    fl = flags_r;
    if (hf_r[0] != magic_word || hf_r[1][31:16] != 16'(HeaderBytes) || hcrc_r != ~crc_r)
      fl[0] = 1'b1;
    if (hf_r[1][15:0] != format_version) fl[1] = 1'b1;
    if (b != 8'd0) fl[2] = 1'b1;
    if (hf_r[3] == 0 || hf_r[4] == 0 || hf_r[5] != hf_r[4] || hf_r[6] == 0) fl[3] = 1'b1;
    pay = {hf_r[3], 4'd0} + {1'b0, hf_r[4], 3'd0} + {hf_r[5], 4'd0} + {hf_r[6], 4'd0};
    if (hf_r[2] < 32'(HeaderBytes) || pay != {4'd0, hf_r[2] - 32'(HeaderBytes)})
      fl[4] = 1'b1;
    if (!fin(hf_r[7]) || !fin(hf_r[8]) || ord(hf_r[7]) >= ord(hf_r[8])) fl[5] = 1'b1;
    if (hf_r[5] > 32'(MaxTracks)) fl[6] = 1'b1;
    herm = ts_rd_r[32];
  end

  // final code of the section with this byte included
  logic [3:0]  fc;
  logic [33:0] cnt_n;
  logic [31:0] crc_fin;
  always_comb begin
    cnt_n = cnt_r + ((cnt_r < CountCap) ? 34'd1 : 34'd0);
    crc_fin = (pos < 34'(HeaderBytes)) ? crc_r : crc_n;
    if (cnt_n < 34'(HeaderBytes) || flags_r[0] || {2'd0, hf_r[2]} != cnt_n) fc = ERR_HDR;
    else if (flags_r[1]) fc = ERR_VER;
    else if (flags_r[2]) fc = ERR_RES;
    else if (flags_r[3]) fc = ERR_CNT;
    else if (flags_r[4] || ~crc_fin != hf_r[9]) fc = ERR_PSIZE;
    else if (flags_r[5]) fc = ERR_TIME;
    else if (flags_r[6]) fc = ERR_OVF;
    else fc = ERR_NONE;
  end

  // record stage: results of the current byte feed the sticky flags;
  // the final compare uses the values after this byte's record work
  logic [3:0]  sticky_n;
  logic        terr_n, kerr_n, have_n, first_n;
  logic [32:0] chan_n, key_n;
  logic [31:0] prev_node_n, prev_t_n, min_n, max_n, kleft_n, ridx_n;
  logic [8:0]  good_n, tpos_n;
  sec_t        sec_nx;
  logic        ts_we;
  logic [7:0]  rbyte_n;
  logic        key_live;
  logic [8:0]  ts_raddr;
  always_comb begin
    sticky_n = sticky_r; terr_n = terr_r; kerr_n = kerr_r; have_n = have_r;
    first_n = first_r; chan_n = chan_cur_r; key_n = key_cur_r;
    prev_node_n = prev_node_r; prev_t_n = prev_t_r; min_n = min_r; max_n = max_r;
    kleft_n = kleft_r; good_n = good_r; tpos_n = tpos_r; sec_nx = sec_r;
    ridx_n = ridx_r; ts_we = 1'b0; rbyte_n = rbyte_r + 8'd1;
    key_live = 1'b0; ts_raddr = tpos_r;
    if (rec_done) begin
      rbyte_n = 8'd0;
      ridx_n = ridx_r + 32'd1;
      unique case (sec_r)
        SEC_BIND: if (sticky_r == 0) begin
          if (w4 == 32'hffff_ffff || w12 == 0 || {1'b0, w8} != chan_cur_r ||
              {1'b0, w12} > {1'b0, hf_r[4]} - chan_cur_r ||
              (ridx_r != 0 && w0 <= prev_node_r)) sticky_n = ERR_BIND;
          else begin
            prev_node_n = w0;
            chan_n = chan_cur_r + {1'b0, w12};
          end
        end
        SEC_CHAN: if (sticky_r == 0 && (w0 != ridx_r || !fin(w4))) sticky_n = ERR_CHAN;
        SEC_TRACK: if (!terr_r) begin
          if (ridx_r >= 32'(MaxTracks) || h2 != 0 || w12 != 0 ||
              (h0 != step_code && h0 != linear_code && h0 != hermite_code) || w8 == 0 ||
              {1'b0, w4} != key_cur_r || {1'b0, w8} > {1'b0, hf_r[6]} - key_cur_r)
            terr_n = 1'b1;
          else begin
            ts_we = 1'b1;
            key_n = key_cur_r + {1'b0, w8};
            good_n = ridx_r[8:0] + 9'd1;
          end
        end
        default: if (!kerr_r && tpos_r < good_r) begin
          if (!fin(w0) || !fin(w4) || (herm && (!fin(w8) || !fin(w12))) ||
              (!first_r && ord(w0) <= ord(prev_t_r))) kerr_n = 1'b1;
          else begin
            prev_t_n = w0;
            if (!have_r) begin min_n = w0; max_n = w0; have_n = 1'b1; end
            else begin
              if (ord(w0) < ord(min_r)) min_n = w0;
              if (ord(w0) > ord(max_r)) max_n = w0;
            end
            first_n = 1'b0;
            kleft_n = kleft_r - 32'd1;
            if (kleft_n == 0) begin
              tpos_n = tpos_r + 9'd1;
              first_n = 1'b1;
              key_live = 1'b1;
              ts_raddr = tpos_n;
            end
          end
        end
      endcase
      if (ridx_n >= sec_n) begin
        // sections with zero records are excluded by the count check
        ridx_n = '0;
        unique case (sec_r)
          SEC_BIND: sec_nx = SEC_CHAN;
          SEC_CHAN: begin
            sec_nx = SEC_TRACK;
            if (sticky_n == 0 && chan_n != {1'b0, hf_r[4]}) sticky_n = ERR_COVER;
          end
          SEC_TRACK: begin
            sec_nx = SEC_KEY;
            tpos_n = '0; first_n = 1'b1; key_live = 1'b1; ts_raddr = '0;
          end
          default: sec_nx = SEC_DONE;
        endcase
      end
    end
  end

  // next keys_left value when a new track starts: written track entry or stored read
  logic [32:0] ts_next;
  logic [31:0] ftime_min, ftime_max;
  logic [3:0]  code_full;
  always_comb begin
    ts_next = '0;
    if (ts_raddr < good_n) begin
      if (ts_we && ts_raddr == {1'b0, ridx_r[7:0]}) ts_next = {h0 == hermite_code, w8};
      else ts_next = tstore_r[ts_raddr[TrackIdxW-1:0]];
    end
    ftime_min = min_n; ftime_max = max_n;
    code_full = fc;
    if (fc == ERR_NONE) begin
      if (sticky_n != 0) code_full = sticky_n;
      else if (kerr_n) code_full = ERR_KEY;
      else if (terr_n) code_full = ERR_TRACK;
      else if (key_n != {1'b0, hf_r[6]} || !have_n || ord(ftime_min) != ord(hf_r[7]) ||
               ord(ftime_max) != ord(hf_r[8])) code_full = ERR_COVER;
    end
  end

  logic rec_act;
  assign rec_act = pos >= 34'(HeaderBytes) && parse_r && sec_r != SEC_DONE;

  always_ff @(posedge clk) begin
    if (in_en && rec_act) begin
      if (rbyte_r < 8'd16) rbuf_r[rbyte_r[3:0]] <= b;
      if (ts_we && ridx_r < 32'(MaxTracks)) tstore_r[ridx_r[TrackIdxW-1:0]] <= {h0 == hermite_code, w8};
      if (key_live) ts_rd_r <= ts_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_en && in_word.last)) begin
      cnt_r <= '0; crc_r <= '1; hcrc_r <= '0; flags_r <= '0; parse_r <= 1'b0;
      for (int i = 0; i < 10; i++) hf_r[i] <= '0;
      sec_r <= SEC_BIND; ridx_r <= '0; rbyte_r <= '0; prev_node_r <= '0;
      chan_cur_r <= '0; key_cur_r <= '0; good_r <= '0; terr_r <= 1'b0; kerr_r <= 1'b0;
      tpos_r <= '0; kleft_r <= '0; first_r <= 1'b1; have_r <= 1'b0;
      prev_t_r <= '0; min_r <= '0; max_r <= '0; sticky_r <= '0;
    end else if (in_en) begin
      cnt_r <= cnt_n;
      if (pos < 34'(HeaderCrcOffset)) begin
        crc_r <= crc_n;
        hf_r[pos[5:2]] <= hf_r[pos[5:2]] | ({24'd0, b} << {pos[1:0], 3'd0});
      end else if (pos < 34'(HeaderResOffset)) begin
        hcrc_r <= hcrc_r | ({24'd0, b} << {pos[1:0], 3'd0});
      end else if (pos < 34'(HeaderBytes)) begin
        if (b != 0) flags_r[2] <= 1'b1;
      end else begin
        crc_r <= crc_n;
      end
      if (pos == 34'(HeaderBytes - 1)) begin
        flags_r <= fl;
        parse_r <= fl == 0;
        crc_r <= '1;
      end
      if (rec_act) begin
        sticky_r <= sticky_n; terr_r <= terr_n; kerr_r <= kerr_n; have_r <= have_n;
        first_r <= first_n; chan_cur_r <= chan_n; key_cur_r <= key_n;
        prev_node_r <= prev_node_n; prev_t_r <= prev_t_n; min_r <= min_n; max_r <= max_n;
        good_r <= good_n; tpos_r <= tpos_n; sec_r <= sec_nx; ridx_r <= ridx_n;
        rbyte_r <= rbyte_n;
        kleft_r <= key_live ? ts_next[31:0] : kleft_n;
      end
    end
  end

  logic [3:0] last_code;
  always_comb begin
    last_code = fc;
    if (pos >= 34'(HeaderBytes)) begin
      if (rec_act) last_code = code_full;
      else if (fc == ERR_NONE) begin
        if (sticky_r != 0) last_code = sticky_r;
        else if (kerr_r) last_code = ERR_KEY;
        else if (terr_r) last_code = ERR_TRACK;
        else if (key_cur_r != {1'b0, hf_r[6]} || !have_r || ord(min_r) != ord(hf_r[7]) ||
                 ord(max_r) != ord(hf_r[8])) last_code = ERR_COVER;
      end
    end
  end

  assign res_en = in_en && in_word.last;
  assign res_code = last_code;
endmodule

// ----- rtl/morph_anim_section_checker_top.sv -----
// A section result passes from the byte queue through the combinational check engine
// into the output register. Throughput: one byte per cycle, set by the byte-wide CRC and
// record check step, while the queue has room and no last byte waits for the result slot.
// Reset (rst_n low, synchronous): stream state cleared, registers to defaults.
// Track store and record buffer hold undefined data until written.
module morph_anim_section_checker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] ok, [4:1] error_code, zero fill above
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import masc_pkg::*;

  logic [31:0] magic_r;
  logic [15:0] version_r, step_r, linear_r, hermite_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0; version_r <= 16'd1; step_r <= '0; linear_r <= 16'd1; hermite_r <= 16'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgMagic: magic_r <= cfg_wdata;
        CfgVersion: version_r <= cfg_wdata[15:0];
        CfgStep: step_r <= cfg_wdata[15:0];
        CfgLinear: linear_r <= cfg_wdata[15:0];
        CfgHermite: hermite_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // front: byte queue; back pressure comes from the result slot
  logic  q_full, q_empty, q_rd;
  word_t q_out, q_in;
  assign q_in = '{data: in_tdata, last: in_tlast};
  assign in_tready = !q_full;

  masc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(in_tvalid && !q_full), .wr_word(q_in), .full(q_full),
    .rd_en(q_rd), .rd_word(q_out), .empty(q_empty)
  );

  // a last word may only leave the queue if the result slot can take it
  logic slot_free;
  assign slot_free = !out_tvalid || out_tready;
  assign q_rd = !q_empty && (!q_out.last || slot_free);

  logic       res_en;
  logic [3:0] res_code;

  masc_engine u_engine (
    .clk(clk), .rst_n(rst_n), .in_en(q_rd), .in_word(q_out),
    .magic_word(magic_r), .format_version(version_r), .step_code(step_r),
    .linear_code(linear_r), .hermite_code(hermite_r),
    .res_en(res_en), .res_code(res_code)
  );

  logic [3:0] code_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (res_en) out_tvalid <= 1'b1;
    else if (out_tready) out_tvalid <= 1'b0;
    if (res_en) code_r <= res_code;
  end

  assign out_tdata = {3'd0, code_r, code_r == 4'd0};

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    res_en |-> slot_free) else $error("result overwrote pending word");
  a_ok_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[4:1] == 4'd0))) else $error("ok mismatch");
  a_code_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:1] <= 4'd12) else $error("bad error code");
endmodule
